// ----- hw/rtl/gcl_pkg.sv -----
package gcl_pkg;

    localparam int MAX_CODEWORDS_DEF = 64;
    localparam int WORD_BITS_DEF     = 24;
    localparam int OUT_LIMIT         = 64;
    localparam int DIST_BITS         = 32;

    localparam int COUNT_W = 7;
    localparam int DIST_W  = 3;
    localparam int CODE_W  = 24;
    localparam int INDEX_W = 6;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic               start;
        logic               search;
        logic               shift;
        logic [COUNT_W-1:0] want;
        logic [DIST_W-1:0]  min_dist;
    } t_ctrl;

    function automatic logic [2:0] nib_count(input logic [3:0] x);
        logic [2:0] c;
        c = 3'(x[0]) + 3'(x[1]) + 3'(x[2]) + 3'(x[3]);
        return c;
    endfunction

    // nibble counts summed as a tree: bytes, halves, total
    function automatic logic [5:0] popcount32(input logic [DIST_BITS-1:0] x);
        logic [3:0] b [4];
        logic [4:0] h [2];
        for (int i = 0; i < 4; i++) begin
            b[i] = 4'(nib_count(x[8*i +: 4])) + 4'(nib_count(x[8*i+4 +: 4]));
        end
        for (int i = 0; i < 2; i++) begin
            h[i] = 5'(b[2*i]) + 5'(b[2*i+1]);
        end
        return 6'(h[0]) + 6'(h[1]);
    endfunction

endpackage

// ----- hw/rtl/gcl_if.sv -----
interface gcl_req_if import gcl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] code_count;
    logic [DIST_W-1:0]  min_distance;

    modport source (output valid, output code_count, output min_distance, input ready);
    modport sink   (input valid, input code_count, input min_distance, output ready);
endinterface

interface gcl_res_if import gcl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CODE_W-1:0]  codeword;
    logic [INDEX_W-1:0] word_index;
    logic               last;
    logic               overflow;

    modport source (output valid, output codeword, output word_index, output last,
                    output overflow, input ready);
    modport sink   (input valid, input codeword, input word_index, input last,
                    input overflow, output ready);
endinterface

// ----- hw/rtl/gcl_cell.sv -----
module gcl_cell import gcl_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int IDX       = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl                i_ctrl,
    input  logic                 i_valid,
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [WORD_BITS-1:0] i_next,
    output logic                 o_valid,
    output logic [WORD_BITS-1:0] o_word,
    output logic [WORD_BITS-1:0] o_store,
    output logic                 o_capture
);

    logic                 r_full;
    logic                 r_pv;
    logic [WORD_BITS-1:0] r_pw;
    logic [WORD_BITS-1:0] r_word;
    logic                 w_en;
    logic                 w_close;

    assign w_en      = 7'(IDX) < i_ctrl.want;
    assign w_close   = popcount32(DIST_BITS'(i_word ^ r_word)) < {3'b000, i_ctrl.min_dist};
    // only the first empty cell ever sees a live candidate
    assign o_capture = i_ctrl.search & i_valid & ~r_full & w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_pv   <= 1'b0;
        end else if (i_ctrl.start) begin
            r_full <= (IDX == 0);
            r_pv   <= 1'b0;
        end else if (i_ctrl.search) begin
            if (r_full) begin
                r_pv <= i_valid & ~w_close;
            end else begin
                r_pv <= 1'b0;
                if (o_capture) begin
                    r_full <= 1'b1;
                end
            end
        end else begin
            r_pv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pw <= i_word;
        if (i_ctrl.start && IDX == 0) begin
            r_word <= '0;
        end else if (o_capture) begin
            r_word <= i_word;
        end else if (i_ctrl.shift) begin
            r_word <= i_next;
        end
    end

    assign o_valid = r_pv;
    assign o_word  = r_pw;
    assign o_store = r_word;

endmodule

// ----- hw/rtl/greedy_lexicode_generator.sv -----
// Greedy lexicode generator. One request (code size, minimum distance) is taken
// at a time; the request channel is not ready again until the last codeword has
// been delivered. Candidates 1, 2, 3, ... enter a chain of one cell per codeword
// (the smaller of MAX_CODEWORDS and 64 cells), one candidate per cycle, and move
// one cell per cycle; each cell checks the passing candidate against its stored
// word and the first empty cell keeps a survivor. If the candidates run out before
// the code is complete, overflow is flagged once the chain has drained. Results then
// shift out of the chain head at one per cycle while the sink is ready.
module greedy_lexicode_generator import gcl_pkg::*; #(
    parameter int MAX_CODEWORDS = MAX_CODEWORDS_DEF,
    parameter int WORD_BITS     = WORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gcl_req_if.sink   i_req,
    gcl_res_if.source o_res
);

    localparam int CELLS   = (MAX_CODEWORDS < OUT_LIMIT) ? MAX_CODEWORDS : OUT_LIMIT;
    localparam int DRAIN_W = $clog2(CELLS + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_OUT    = 2'd3;

    logic [1:0]           r_state;
    logic [COUNT_W-1:0]   r_want;
    logic [DIST_W-1:0]    r_dist;
    logic [COUNT_W-1:0]   r_found;
    logic [WORD_BITS:0]   r_cand;
    logic [DRAIN_W-1:0]   r_drain;
    logic [INDEX_W-1:0]   r_idx;
    logic                 r_ovf;

    logic                 w_req_go;
    logic                 w_res_go;
    logic                 w_inject;
    logic                 w_cap_any;
    logic                 w_done;
    logic                 w_last;
    logic [COUNT_W-1:0]   w_want;
    logic [31:0]          w_head32;
    t_ctrl                w_ctrl;

    logic                 w_v  [CELLS+1];
    logic [WORD_BITS-1:0] w_w  [CELLS+1];
    logic [WORD_BITS-1:0] w_st [CELLS];
    logic [CELLS-1:0]     w_cap;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_req_go    = i_req.valid & i_req.ready;
    assign w_res_go    = o_res.valid & o_res.ready;
    assign w_done      = (r_found == r_want);
    assign w_inject    = (r_state == S_SEARCH) & ~r_cand[WORD_BITS] & ~w_done;
    assign w_cap_any   = |w_cap;

    always_comb begin
        w_want = i_req.code_count;
        if (w_want == '0) begin
            w_want = 7'd1;
        end else if (w_want > 7'(CELLS)) begin
            w_want = 7'(CELLS);
        end
    end

    always_comb begin
        w_ctrl.start    = w_req_go;
        w_ctrl.search   = (r_state == S_SEARCH) | (r_state == S_DRAIN);
        w_ctrl.shift    = w_res_go;
        w_ctrl.want     = r_want;
        w_ctrl.min_dist = r_dist;
    end

    assign w_v[0] = w_inject;
    assign w_w[0] = r_cand[WORD_BITS-1:0];

    for (genvar j = 0; j < CELLS; j++) begin : g_cell
        logic [WORD_BITS-1:0] w_next;
        if (j == CELLS - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_st[j+1];
        end
        gcl_cell #(
            .WORD_BITS (WORD_BITS),
            .IDX       (j)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_valid   (w_v[j]),
            .i_word    (w_w[j]),
            .i_next    (w_next),
            .o_valid   (w_v[j+1]),
            .o_word    (w_w[j+1]),
            .o_store   (w_st[j]),
            .o_capture (w_cap[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= '0;
            r_cand  <= '0;
            r_drain <= '0;
            r_idx   <= '0;
            r_ovf   <= 1'b0;
            r_want  <= '0;
            r_dist  <= '0;
        end else begin
            if (w_cap_any) begin
                r_found <= r_found + 7'd1;
            end
            if (w_inject) begin
                r_cand <= r_cand + (WORD_BITS+1)'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_req_go) begin
                        r_want  <= w_want;
                        r_dist  <= i_req.min_distance;
                        r_found <= 7'd1;
                        r_cand  <= (WORD_BITS+1)'(1);
                        r_idx   <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (w_done) begin
                        r_state <= S_OUT;
                    end else if (r_cand[WORD_BITS]) begin
                        r_drain <= '0;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // let candidates still in the chain land before giving up
                    if (w_done) begin
                        r_state <= S_OUT;
                    end else if (r_drain == DRAIN_W'(CELLS)) begin
                        r_ovf   <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_drain <= r_drain + DRAIN_W'(1);
                    end
                end
                S_OUT: begin
                    if (w_res_go) begin
                        r_idx <= r_idx + INDEX_W'(1);
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign w_last   = (7'(r_idx) + 7'd1 == r_found);
    assign w_head32 = 32'(w_st[0]);

    assign o_res.valid      = (r_state == S_OUT);
    assign o_res.codeword   = w_head32[CODE_W-1:0];
    assign o_res.word_index = r_idx;
    assign o_res.last       = w_last;
    assign o_res.overflow   = w_last & r_ovf;

endmodule

// ----- hw/rtl/gcl_checker.sv -----
module gcl_checker import gcl_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_req_valid,
    input logic               i_req_ready,
    input logic               i_res_valid,
    input logic               i_res_ready,
    input logic [CODE_W-1:0]  i_codeword,
    input logic [INDEX_W-1:0] i_word_index,
    input logic               i_last,
    input logic               i_overflow
);

    // overflow only ever rides on the closing transaction
    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_overflow) |-> i_last)
        else $error("overflow without last");

    // a new request is never taken while results are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_ready |-> !i_res_valid)
        else $error("request ready while result pending");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_ready && !i_last) |=>
        (i_res_valid && i_word_index == $past(i_word_index) + 6'd1))
        else $error("word index did not advance");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
        (i_res_valid && $stable(i_codeword) && $stable(i_word_index) && $stable(i_last)))
        else $error("stalled result changed");

    // one request at a time
    a_req_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request channel stayed ready after a transaction");

endmodule

bind greedy_lexicode_generator gcl_checker u_gcl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_codeword   (o_res.codeword),
    .i_word_index (o_res.word_index),
    .i_last       (o_res.last),
    .i_overflow   (o_res.overflow)
);

// ----- sim/greedy_lexicode_generator_test.sv -----
`timescale 1ns / 1ps

module greedy_lexicode_generator_test;
    import gcl_pkg::*;

    localparam int WORD_LIMIT_BITS = WORD_BITS_DEF;
    localparam int CODE_SLOTS      = (MAX_CODEWORDS_DEF < OUT_LIMIT) ? MAX_CODEWORDS_DEF
                                                                     : OUT_LIMIT;
    localparam int RANDOM_REQUESTS = 72;
    localparam int CALM_REQUESTS   = 30;
    localparam int HOLD_REQUESTS   = 4;
    localparam int LONG_HOLD       = 400;
    localparam int DRAIN_CYCLES    = 2 * CODE_SLOTS + 20;
    // worst search stays below 2**17 candidates for the mixes used here,
    // plus every result waiting out a full stall burst
    localparam longint CYCLE_LIMIT = 140 * ((longint'(1) << 17) + CODE_SLOTS * 14);

    typedef struct packed {
        logic [CODE_W-1:0]  word;
        logic [INDEX_W-1:0] index;
        logic               last;
        logic               ovf;
    } t_code_result;

    typedef struct packed {
        logic [COUNT_W-1:0]       count;
        logic [DIST_W-1:0]        distance;
        logic [2:0]               n_typed;
        logic [3:0][CODE_W-1:0]   words;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;

    gcl_req_if req_ch();
    gcl_res_if res_ch();

    t_code_result   pending_results[$];
    t_directed_row  directed_rows[$];

    // greedy codes per distance, grown on demand; each request's code is a prefix
    logic [CODE_W-1:0] lex_table [8][CODE_SLOTS];
    int                lex_len   [8];
    longint            lex_next  [8];

    int     mismatch_count = 0;
    longint cycle_count    = 0;
    bit     idle_on        = 1'b1;
    bit     hold_request   = 1'b0;

    greedy_lexicode_generator #(
        .MAX_CODEWORDS(MAX_CODEWORDS_DEF),
        .WORD_BITS    (WORD_LIMIT_BITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_res  (res_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic note_mismatch(input string what, input t_code_result want_r,
                                 input t_code_result seen);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%0t %s: expected word %h idx %0d last %0b ovf %0b, ",
                      "got word %h idx %0d last %0b ovf %0b"},
                     $realtime, what, want_r.word, want_r.index, want_r.last, want_r.ovf,
                     seen.word, seen.index, seen.last, seen.ovf);
    endtask

    // expected codewords for one request
    task automatic predict_lexicode(input logic [COUNT_W-1:0] count,
                                    input logic [DIST_W-1:0] distance);
        int           want;
        int           n;
        int           d;
        int           j;
        bit           keep;
        bit           ovf;
        logic [31:0]  diff;
        t_code_result r;
        d = int'(distance);
        want = (count == 0) ? 1 : int'(count);
        if (want > CODE_SLOTS)
            want = CODE_SLOTS;
        while (lex_len[d] < want && lex_next[d] < (longint'(1) << WORD_LIMIT_BITS)) begin
            keep = 1'b1;
            j = 0;
            while (keep && j < lex_len[d]) begin
                diff = 32'(lex_next[d]) ^ 32'(lex_table[d][j]);
                if ($countones(diff) < d)
                    keep = 1'b0;
                j++;
            end
            if (keep) begin
                lex_table[d][lex_len[d]] = CODE_W'(lex_next[d]);
                lex_len[d]++;
            end
            lex_next[d]++;
        end
        ovf = (lex_len[d] < want);
        n = ovf ? lex_len[d] : want;
        for (j = 0; j < n; j++) begin
            r.word  = lex_table[d][j];
            r.index = INDEX_W'(j);
            r.last  = (j == n - 1);
            r.ovf   = r.last && ovf;
            pending_results.push_back(r);
        end
    endtask

    task automatic add_row(input int count, input int distance, input int n_typed,
                           input logic [CODE_W-1:0] w0, input logic [CODE_W-1:0] w1,
                           input logic [CODE_W-1:0] w2, input logic [CODE_W-1:0] w3);
        t_directed_row row;
        row.count    = COUNT_W'(count);
        row.distance = DIST_W'(distance);
        row.n_typed  = 3'(n_typed);
        row.words    = {w3, w2, w1, w0};
        directed_rows.push_back(row);
    endtask

    // entered right after a falling edge, returns right after one
    task automatic offer_request(input logic [COUNT_W-1:0] count,
                                 input logic [DIST_W-1:0] distance, input int n_typed,
                                 input logic [3:0][CODE_W-1:0] words);
        int           k;
        t_code_result r;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.code_count   <= count;
        req_ch.min_distance <= distance;
        do @(posedge i_clk); while (!req_ch.ready);
        if (n_typed == 0) begin
            predict_lexicode(count, distance);
        end else begin
            for (k = 0; k < n_typed; k++) begin
                r.word  = words[k];
                r.index = INDEX_W'(k);
                r.last  = (k == n_typed - 1);
                r.ovf   = 1'b0;
                pending_results.push_back(r);
            end
        end
        @(negedge i_clk);
    endtask

    // large counts only where the search stays short
    task automatic pick_request(output logic [COUNT_W-1:0] cnt, output logic [DIST_W-1:0] dst);
        bit rare;
        dst  = DIST_W'($urandom_range(0, 7));
        rare = ($urandom_range(0, 9) == 0);
        if (dst <= 4)
            cnt = rare ? COUNT_W'($urandom_range(64, 127)) : COUNT_W'($urandom_range(0, 63));
        else if (dst <= 6)
            cnt = rare ? COUNT_W'($urandom_range(17, 63)) : COUNT_W'($urandom_range(0, 16));
        else
            cnt = rare ? COUNT_W'($urandom_range(9, 32)) : COUNT_W'($urandom_range(0, 8));
    endtask

    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_code_result seen;
        t_code_result want_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            seen = {res_ch.codeword, res_ch.word_index, res_ch.last, res_ch.overflow};
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected transaction", '0, seen);
            end else begin
                want_r = pending_results.pop_front();
                if (seen !== want_r)
                    note_mismatch("codeword mismatch", want_r, seen);
            end
        end
    end

    initial begin
        int                 k;
        logic [COUNT_W-1:0] cnt;
        logic [DIST_W-1:0]  dst;
        t_directed_row      row;

        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.code_count   = '0;
        req_ch.min_distance = '0;
        for (k = 0; k < 8; k++) begin
            lex_table[k][0] = '0;
            lex_len[k]      = 1;
            lex_next[k]     = 1;
        end

        // a zero count, like a count of one, gives the zero word alone
        add_row(0, 3, 1, 0, 0, 0, 0);
        add_row(0, 0, 1, 0, 0, 0, 0);
        add_row(1, 7, 1, 0, 0, 0, 0);
        // distance 0 or 1 takes every candidate; small codes at larger distances follow
        add_row(4, 0, 4, 0, 1, 2, 3);
        add_row(4, 1, 4, 0, 1, 2, 3);
        add_row(4, 2, 4, 0, 'h3, 'h5, 'h6);
        add_row(3, 3, 3, 0, 'h7, 'h19, 0);
        add_row(2, 4, 2, 0, 'hf, 0, 0);
        add_row(2, 7, 2, 0, 'h7f, 0, 0);
        // counts above the store saturate; full-size codes at every distance
        add_row(127, 0, 0, 0, 0, 0, 0);
        add_row(64, 0, 0, 0, 0, 0, 0);
        add_row(65, 1, 0, 0, 0, 0, 0);
        add_row(100, 2, 0, 0, 0, 0, 0);
        add_row(64, 3, 0, 0, 0, 0, 0);
        add_row(96, 3, 0, 0, 0, 0, 0);
        add_row(64, 4, 0, 0, 0, 0, 0);
        add_row(33, 4, 0, 0, 0, 0, 0);
        add_row(64, 5, 0, 0, 0, 0, 0);
        add_row(8, 5, 0, 0, 0, 0, 0);
        add_row(64, 6, 0, 0, 0, 0, 0);
        add_row(16, 6, 0, 0, 0, 0, 0);
        add_row(64, 7, 0, 0, 0, 0, 0);
        add_row(5, 7, 0, 0, 0, 0, 0);
        add_row(7, 2, 0, 0, 0, 0, 0);
        // search overflow needs 2**24 candidates at this word width, far past the run

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            offer_request(row.count, row.distance, int'(row.n_typed), row.words);
        end

        // quiet the request side until every codeword is back
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);

        // results held back while requests keep coming, so the input stalls
        hold_request = 1'b1;
        for (k = 0; k < HOLD_REQUESTS; k++) begin
            pick_request(cnt, dst);
            offer_request(cnt, dst, 0, '0);
        end

        for (k = 0; k < RANDOM_REQUESTS; k++) begin
            if (k == RANDOM_REQUESTS - CALM_REQUESTS)
                idle_on = 1'b0;
            pick_request(cnt, dst);
            offer_request(cnt, dst, 0, '0);
        end

        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
